### rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer: phase and
// opcode codes, error codes, length limits and the queue item layout.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Payload length as decoded from the frame header
    localparam int LEN_W       = 64;
    localparam int LENGTH_BITS = 64;
    localparam int LIMIT_W     = 63;

    localparam logic [LEN_W-1:0] TOP_BIT      = 64'h8000_0000_0000_0000;
    localparam logic [LEN_W-1:0] LEN_FIT_MASK =
        64'hFFFF_FFFF_FFFF_FFFF >> (LEN_W - LENGTH_BITS);
    localparam logic [LIMIT_W-1:0] MAX_LEN_RESET = 63'd16777216;

    // Register map
    localparam logic [2:0] ADDR_MAX_FRAME_LEN = 3'd0;

    // Seven-bit length codes
    localparam logic [6:0] SHORT_MAX  = 7'd125;
    localparam logic [6:0] LEN16_CODE = 7'd126;

    // Extended length byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    // Control bit of the opcode
    localparam int CTRL_BIT = 3;

    // Opcodes
    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    // Parser phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_LEN_EXT = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // Error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_RSV        = 4'd1;
    localparam logic [3:0] ERR_STRAY_CONT = 4'd2;
    localparam logic [3:0] ERR_EXP_CONT   = 4'd3;
    localparam logic [3:0] ERR_RSV_OP     = 4'd4;
    localparam logic [3:0] ERR_CTRL_FIN   = 4'd5;
    localparam logic [3:0] ERR_UNMASKED   = 4'd6;
    localparam logic [3:0] ERR_CTRL_EXT   = 4'd7;
    localparam logic [3:0] ERR_LEN_TOP    = 4'd8;
    localparam logic [3:0] ERR_OVER_LIMIT = 4'd9;

    // Queue between parser and output stage
    localparam int Q_DEPTH = 2;
    localparam int QA_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // One classified result on its way to the output stage
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       data_valid;
        logic [3:0] opcode;
        logic       fin;
        logic       frame_end;
        logic       empty;
        logic [3:0] err;
    } t_q_item;

endpackage

### rtl/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// Frame parser: takes one stream byte a cycle while the queue has room,
// tracks header/length/key phases, checks frame rules, pushes classified results.
// ----------------------------------------------------------------------------
module wsd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [7:0]                   i_in_byte,
    output logic                         o_in_stall,
    input  logic [wsd_pkg::LIMIT_W-1:0]  i_max_frame_len,
    input  logic                         i_q_full,
    output logic                         o_push,
    output wsd_pkg::t_q_item             o_item
);
    import wsd_pkg::*;

    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_hdr, n_hdr;
    logic [1:0]       r_open, n_open;
    logic [LEN_W-1:0] r_len, n_len;
    logic [3:0]       r_left, n_left;
    logic [1:0]       r_midx, n_midx;
    logic [LEN_W-1:0] r_remain, n_remain;
    logic             r_err, n_err;
    logic [7:0]       r_key [4];

    logic             accept;
    logic             key_we;
    logic [3:0]       op;
    logic [3:0]       err;
    logic [3:0]       len_err;
    logic             last;

    // Length rules: top bit, fit into the length width, configured limit
    function automatic logic [3:0] check_length(input logic [LEN_W-1:0] len,
                                                input logic [LIMIT_W-1:0] lim);
        logic [3:0] code;
        code = ERR_NONE;
        if ((len & TOP_BIT) != '0) begin
            code = ERR_LEN_TOP;
        end else if ((len & ~LEN_FIT_MASK) != '0) begin
            code = ERR_OVER_LIMIT;
        end else if (len > {1'b0, lim}) begin
            code = ERR_OVER_LIMIT;
        end
        return code;
    endfunction

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign op         = i_in_byte[3:0];
    assign last       = (r_remain == LEN_W'(1));

    // Advance the parser by one byte
    always_comb begin
        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_open   = r_open;
        n_len    = r_len;
        n_left   = r_left;
        n_midx   = r_midx;
        n_remain = r_remain;
        n_err    = r_err;
        key_we   = 1'b0;
        err      = ERR_NONE;
        len_err  = ERR_NONE;
        o_push   = 1'b0;
        o_item   = '0;

        if (accept && !r_err) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_hdr  = i_in_byte;
                    n_midx = 2'd0;
                    if (i_in_byte[6:4] != 3'd0) begin
                        err = ERR_RSV;
                    end else begin
                        unique case (op) inside
                            OP_CONT: begin
                                if (r_open == 2'd0) err = ERR_STRAY_CONT;
                            end
                            OP_TEXT, OP_BINARY: begin
                                if (r_open != 2'd0) begin
                                    err = ERR_EXP_CONT;
                                end else if (!i_in_byte[7]) begin
                                    n_open = op[1:0];
                                end
                            end
                            OP_CLOSE, OP_PING, OP_PONG: begin
                                if (!i_in_byte[7]) err = ERR_CTRL_FIN;
                            end
                            default: err = ERR_RSV_OP;
                        endcase
                    end
                    if (err == ERR_NONE) n_phase = PH_LEN;
                end
                PH_LEN: begin
                    if (!i_in_byte[7]) begin
                        err = ERR_UNMASKED;
                    end else if (i_in_byte[6:0] <= SHORT_MAX) begin
                        n_len   = LEN_W'(i_in_byte[6:0]);
                        len_err = check_length(n_len, i_max_frame_len);
                        err     = len_err;
                        if (len_err == ERR_NONE) n_phase = PH_MASK;
                    end else begin
                        n_left = (i_in_byte[6:0] == LEN16_CODE) ? EXT16_BYTES
                                                                : EXT64_BYTES;
                        n_len  = '0;
                        if (r_hdr[CTRL_BIT]) begin
                            err = ERR_CTRL_EXT;
                        end else begin
                            n_phase = PH_LEN_EXT;
                        end
                    end
                end
                PH_LEN_EXT: begin
                    n_len  = {r_len[LEN_W-9:0], i_in_byte};
                    n_left = r_left - 4'd1;
                    if (n_left == 4'd0) begin
                        len_err = check_length(n_len, i_max_frame_len);
                        err     = len_err;
                        if (len_err == ERR_NONE) n_phase = PH_MASK;
                    end
                end
                PH_MASK: begin
                    key_we = 1'b1;
                    n_midx = r_midx + 2'd1;
                    if (r_midx == 2'd3) begin
                        n_remain = r_len;
                        if (r_len != '0) begin
                            n_phase = PH_PAYLOAD;
                        end else begin
                            // Zero-length frame: finish and emit the empty mark
                            if (r_hdr[3:0] <= OP_BINARY && r_hdr[7]) n_open = 2'd0;
                            n_phase          = PH_HEADER;
                            o_push           = 1'b1;
                            o_item.opcode    = r_hdr[3:0];
                            o_item.fin       = r_hdr[7];
                            o_item.frame_end = 1'b1;
                            o_item.empty     = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_midx   = r_midx + 2'd1;
                    n_remain = r_remain - LEN_W'(1);
                    if (last) begin
                        if (r_hdr[3:0] <= OP_BINARY && r_hdr[7]) n_open = 2'd0;
                        n_phase = PH_HEADER;
                    end
                    // Swallow pong payload
                    if (r_hdr[3:0] != OP_PONG) begin
                        o_push            = 1'b1;
                        o_item.data       = i_in_byte;
                        o_item.key        = r_key[r_midx];
                        o_item.data_valid = 1'b1;
                        o_item.opcode     = r_hdr[3:0];
                        o_item.fin        = r_hdr[7];
                        o_item.frame_end  = last;
                    end
                end
                default: n_phase = PH_HEADER;
            endcase

            // Report an error once and latch it
            if (err != ERR_NONE) begin
                n_err         = 1'b1;
                o_push        = 1'b1;
                o_item        = '0;
                o_item.opcode = n_hdr[3:0];
                o_item.fin    = n_hdr[7];
                o_item.err    = err;
            end
        end
    end

    // Hold parser control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hdr    <= '0;
            r_open   <= '0;
            r_len    <= '0;
            r_left   <= '0;
            r_midx   <= '0;
            r_remain <= '0;
            r_err    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hdr    <= n_hdr;
            r_open   <= n_open;
            r_len    <= n_len;
            r_left   <= n_left;
            r_midx   <= n_midx;
            r_remain <= n_remain;
            r_err    <= n_err;
        end
    end

    // Capture masking key bytes
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[r_midx] <= i_in_byte;
        end
    end

    a_no_push_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !o_push)
        else $error("result pushed after an error was latched");

    a_error_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.err != ERR_NONE) |=> r_err)
        else $error("error result did not latch the error flag");

    a_empty_from_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.empty) |-> (o_item.frame_end && r_phase == PH_MASK))
        else $error("empty mark outside the key phase");

endmodule

### rtl/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue
// Short FIFO of classified results between the parser and the output
// stage, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module wsd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsd_pkg::t_q_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output wsd_pkg::t_q_item o_item
);
    import wsd_pkg::*;

    t_q_item         r_mem [Q_DEPTH];
    logic [QA_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QA_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QC_W-1:0] r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == QC_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QA_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QA_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push not reflected in the count");

endmodule

### rtl/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: pops classified results, unmasks payload bytes and holds
// each result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  wsd_pkg::t_q_item i_q_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_data,
    output logic             o_data_valid,
    output logic [3:0]       o_frame_opcode,
    output logic             o_frame_fin,
    output logic             o_frame_end,
    output logic             o_empty_frame,
    output logic [3:0]       o_error_code
);
    import wsd_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_data_valid;
    logic [3:0] r_opcode;
    logic       r_fin;
    logic       r_end;
    logic       r_empty;
    logic [3:0] r_err;
    logic       load;

    // Load when the output register is free or being taken
    assign load  = i_q_valid && (!r_valid || !i_out_stall);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Unmask and hold the result
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data       <= i_q_item.data ^ i_q_item.key;
            r_data_valid <= i_q_item.data_valid;
            r_opcode     <= i_q_item.opcode;
            r_fin        <= i_q_item.fin;
            r_end        <= i_q_item.frame_end;
            r_empty      <= i_q_item.empty;
            r_err        <= i_q_item.err;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_data     = r_data;
    assign o_data_valid   = r_data_valid;
    assign o_frame_opcode = r_opcode;
    assign o_frame_fin    = r_fin;
    assign o_frame_end    = r_end;
    assign o_empty_frame  = r_empty;
    assign o_error_code   = r_err;

    a_data_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data_valid) |-> (r_err == ERR_NONE && !r_empty))
        else $error("payload byte flagged as error or empty mark");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_empty) |-> (r_end && !r_data_valid))
        else $error("empty mark without frame end");

    a_load_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_valid)
        else $error("popped result not presented");

endmodule

### rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Client-to-server WebSocket frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_byte) carries the client
//   byte stream, one byte per transaction. Output channel (o_out_valid /
//   i_out_stall) carries at most one result per input byte: an unmasked
//   payload byte, an empty-frame end mark, or an error report. Header,
//   length and key bytes, and pong payload, give no result.
//   Throughput is one byte per cycle while the queue is not full. A result
//   passes through the two-entry result queue and then the output register:
//   the edge that accepts its byte writes it into the queue, and a later edge
//   loads it into the output register.
//   When the receiver stalls, the output register holds its transaction,
//   the queue fills, and o_in_stall rises once the queue is full.
//   Errors are reported once; every later byte is taken and dropped until
//   reset. Reset clears the parser, the queue and the output register and
//   sets max_frame_len to 16 MiB.
//   max_frame_len sits at APB byte address 0 (64-bit data, 63 bits used);
//   write it only while the block is idle.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_data,
    output logic        o_data_valid,
    output logic [3:0]  o_frame_opcode,
    output logic        o_frame_fin,
    output logic        o_frame_end,
    output logic        o_empty_frame,
    output logic [3:0]  o_error_code,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import wsd_pkg::*;

    logic [LIMIT_W-1:0] r_max_len;
    logic               cfg_wr;
    logic               q_full;
    logic               push;
    t_q_item            push_item;
    logic               q_valid;
    t_q_item            q_item;
    logic               pop;

    // Register file: one limit register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MAX_FRAME_LEN);
    assign prdata = (paddr == ADDR_MAX_FRAME_LEN) ? {1'b0, r_max_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (cfg_wr) begin
            r_max_len <= pwdata[LIMIT_W-1:0];
        end
    end

    wsd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_byte       (i_in_byte),
        .o_in_stall      (o_in_stall),
        .i_max_frame_len (r_max_len),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_item          (push_item)
    );

    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    wsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data),
        .o_data_valid   (o_data_valid),
        .o_frame_opcode (o_frame_opcode),
        .o_frame_fin    (o_frame_fin),
        .o_frame_end    (o_frame_end),
        .o_empty_frame  (o_empty_frame),
        .o_error_code   (o_error_code)
    );

endmodule

### test/tb_websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer
// Self-checking testbench for the WebSocket frame deframer. Builds masked
// client frames (all opcodes, 7/16/64-bit length codes, empty and long
// payloads, fragmented messages with interleaved control frames) under
// several max_frame_len settings and idle/stall patterns. A byte-level
// predictor tracks the parser and queues the expected results for the
// output monitor. The run ends with one randomly chosen protocol error,
// followed by trailing bytes that must be dropped.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam int         CYCLE_LIMIT        = 400000;
    localparam int         SETTLE_CYCLES      = 8;
    localparam logic [6:0] LEN64_CODE         = 7'd127;
    localparam logic [3:0] NO_MESSAGE         = 4'd0;
    localparam int         LONG_CAP           = 300;

    typedef enum logic [1:0] {LEN_ENC7, LEN_ENC16, LEN_ENC64} t_len_enc;
    typedef enum logic [1:0] {PAY_RANDOM, PAY_ZEROS, PAY_ONES} t_pay_pat;

    // One expected output transaction
    typedef struct packed {
        logic [7:0] data;
        logic       dv;
        logic [3:0] op;
        logic       fin;
        logic       fend;
        logic       empty;
        logic [3:0] err;
    } t_ws_result;

    // Clock, reset and block inputs
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [63:0] pwdata    = '0;

    // Block outputs
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  out_data;
    logic        data_valid;
    logic [3:0]  frame_opcode;
    logic        frame_fin;
    logic        frame_end;
    logic        empty_frame;
    logic [3:0]  error_code;
    logic [63:0] prdata;
    logic        pready;

    // Stimulus and scoreboard storage
    logic [7:0]  client_bytes[$];
    t_ws_result  awaited_results[$];
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    int          fail_cnt        = 0;
    int          checked_cnt     = 0;
    int          bytes_queued    = 0;
    int          frames_sent     = 0;
    int          limit_writes    = 0;
    int          cycle_cnt       = 0;
    logic        msg_open        = 1'b0;

    // Parser state mirrored by the predictor
    logic [62:0] frame_len_limit = MAX_LEN_RESET;
    logic [2:0]  parse_ph        = PH_HEADER;
    logic [7:0]  hdr             = 8'h00;
    logic [3:0]  open_type       = NO_MESSAGE;
    logic [63:0] plen            = '0;
    logic [3:0]  len_left        = '0;
    logic [7:0]  mask_key[4]     = '{default: 8'h00};
    logic [1:0]  kidx            = '0;
    logic [63:0] done_cnt        = '0;
    logic        parse_stuck     = 1'b0;

    websocket_frame_deframer dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_data     (out_data),
        .o_data_valid   (data_valid),
        .o_frame_opcode (frame_opcode),
        .o_frame_fin    (frame_fin),
        .o_frame_end    (frame_end),
        .o_empty_frame  (empty_frame),
        .o_error_code   (error_code),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Queue one expected transaction; an error code latches the parser
    task automatic emit(input logic [7:0] data, input logic dv, input logic fend,
                        input logic empty, input logic [3:0] err);
        t_ws_result r;
        r.data  = data;
        r.dv    = dv;
        r.op    = hdr[3:0];
        r.fin   = hdr[7];
        r.fend  = fend;
        r.empty = empty;
        r.err   = err;
        if (err != ERR_NONE)
            parse_stuck = 1'b1;
        awaited_results.push_back(r);
    endtask

    function automatic logic [3:0] length_fault(input logic [63:0] len);
        if ((len & TOP_BIT) != '0)
            return ERR_LEN_TOP;
        if ((len & ~LEN_FIT_MASK) != '0)
            return ERR_OVER_LIMIT;
        if (len > {1'b0, frame_len_limit})
            return ERR_OVER_LIMIT;
        return ERR_NONE;
    endfunction

    // A completed data frame with FIN closes the open message
    task automatic close_frame();
        if (hdr[3:0] <= OP_BINARY && hdr[7])
            open_type = NO_MESSAGE;
        parse_ph = PH_HEADER;
    endtask

    // Advance the parser by one accepted client byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [3:0] op;
        logic [3:0] code;
        logic [7:0] data;
        logic       last;
        logic       op_known;
        if (parse_stuck)
            return;
        case (parse_ph)
            PH_HEADER: begin
                op       = b[3:0];
                op_known = (op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
                            op == OP_CLOSE || op == OP_PING || op == OP_PONG);
                hdr  = b;
                kidx = '0;
                if (b[6:4] != 3'b000) begin
                    emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_RSV);
                end else if (op == OP_CONT && open_type == NO_MESSAGE) begin
                    emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_STRAY_CONT);
                end else if ((op == OP_TEXT || op == OP_BINARY) && open_type != NO_MESSAGE) begin
                    emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_EXP_CONT);
                end else if (!op_known) begin
                    emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_RSV_OP);
                end else if (b[CTRL_BIT] && !b[7]) begin
                    emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_CTRL_FIN);
                end else begin
                    if ((op == OP_TEXT || op == OP_BINARY) && !b[7])
                        open_type = op;
                    parse_ph = PH_LEN;
                end
            end
            PH_LEN: begin
                if (!b[7]) begin
                    emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_UNMASKED);
                end else if (b[6:0] <= SHORT_MAX) begin
                    plen = 64'(b[6:0]);
                    code = length_fault(plen);
                    if (code != ERR_NONE)
                        emit(8'h00, 1'b0, 1'b0, 1'b0, code);
                    else
                        parse_ph = PH_MASK;
                end else begin
                    len_left = (b[6:0] == LEN16_CODE) ? EXT16_BYTES : EXT64_BYTES;
                    plen     = '0;
                    if (hdr[CTRL_BIT])
                        emit(8'h00, 1'b0, 1'b0, 1'b0, ERR_CTRL_EXT);
                    else
                        parse_ph = PH_LEN_EXT;
                end
            end
            PH_LEN_EXT: begin
                plen     = {plen[55:0], b};
                len_left = len_left - 4'd1;
                if (len_left == '0) begin
                    code = length_fault(plen);
                    if (code != ERR_NONE)
                        emit(8'h00, 1'b0, 1'b0, 1'b0, code);
                    else
                        parse_ph = PH_MASK;
                end
            end
            PH_MASK: begin
                mask_key[kidx] = b;
                kidx           = kidx + 2'd1;
                if (kidx == '0) begin
                    done_cnt = '0;
                    if (plen != '0) begin
                        parse_ph = PH_PAYLOAD;
                    end else begin
                        close_frame();
                        emit(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                    end
                end
            end
            PH_PAYLOAD: begin
                data     = b ^ mask_key[kidx];
                kidx     = kidx + 2'd1;
                done_cnt = done_cnt + 64'd1;
                last     = (done_cnt >= plen);
                if (last)
                    close_frame();
                // Pong payload is swallowed
                if (hdr[3:0] != OP_PONG)
                    emit(data, 1'b1, last, 1'b0, ERR_NONE);
            end
            default: begin
                parse_ph = PH_HEADER;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Frame builder
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b);
        client_bytes.push_back(b);
        bytes_queued++;
    endtask

    // Build one masked client frame
    task automatic push_frame(input logic fin, input logic [3:0] op, input int unsigned len,
                              input t_len_enc enc, input t_pay_pat pat);
        logic [7:0]  key[4];
        logic [63:0] lw;
        logic [7:0]  plain;
        lw = 64'(len);
        queue_byte({fin, 3'b000, op});
        case (enc)
            LEN_ENC7: begin
                queue_byte({1'b1, lw[6:0]});
            end
            LEN_ENC16: begin
                queue_byte({1'b1, LEN16_CODE});
                queue_byte(lw[15:8]);
                queue_byte(lw[7:0]);
            end
            default: begin
                queue_byte({1'b1, LEN64_CODE});
                for (int i = 7; i >= 0; i--)
                    queue_byte(lw[i*8 +: 8]);
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            key[i] = 8'($urandom_range(255));
            queue_byte(key[i]);
        end
        for (int unsigned i = 0; i < len; i++) begin
            case (pat)
                PAY_ZEROS: plain = 8'h00;
                PAY_ONES:  plain = 8'hFF;
                default:   plain = 8'($urandom_range(255));
            endcase
            queue_byte(plain ^ key[i % 4]);
        end
        if (!op[CTRL_BIT])
            msg_open = !fin;
        frames_sent++;
    endtask

    // Mostly short payloads, some empty, some at the limit, a few long
    function automatic int unsigned pick_len(input int unsigned cap);
        int unsigned r;
        r = $urandom_range(99);
        if (cap == 0 || r < 10)
            return 0;
        if (r < 18 && cap < LONG_CAP)
            return cap;
        if (r < 22 && cap > SHORT_MAX)
            return $urandom_range(cap, SHORT_MAX + 1);
        return $urandom_range((cap < 12) ? cap : 12, 1);
    endfunction

    // Pick a frame that keeps the message sequence legal
    task automatic push_random_frame(input int unsigned cap);
        logic [3:0]  op;
        logic        fin;
        int unsigned len;
        int unsigned r;
        t_len_enc    enc;
        r = $urandom_range(99);
        if (r < 25) begin
            case ($urandom_range(2))
                0:       op = OP_CLOSE;
                1:       op = OP_PING;
                default: op = OP_PONG;
            endcase
            fin = 1'b1;
            len = pick_len((cap > SHORT_MAX) ? SHORT_MAX : cap);
            enc = LEN_ENC7;
        end else begin
            op  = msg_open ? OP_CONT : ($urandom_range(1) ? OP_BINARY : OP_TEXT);
            fin = ($urandom_range(2) != 0);
            len = pick_len(cap);
            r   = $urandom_range(99);
            if (len > SHORT_MAX)
                enc = (r < 60) ? LEN_ENC16 : LEN_ENC64;
            else
                enc = (r < 60) ? LEN_ENC7 : ((r < 80) ? LEN_ENC16 : LEN_ENC64);
        end
        push_frame(fin, op, len, enc, PAY_RANDOM);
    endtask

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // Wait for all bytes to be taken and all results to arrive
    task automatic drain();
        while (client_bytes.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of max_frame_len: setup cycle, then access until pready
    task automatic write_frame_limit(input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_FRAME_LEN;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frame_len_limit = value[62:0];
        limit_writes++;
    endtask

    // One limit setting with its idle pattern and a byte budget
    task automatic run_phase(input logic [63:0] limit_word, input int idle_pct,
                             input int stall_pct, input int n_bytes);
        int          goal;
        int unsigned cap;
        write_frame_limit(limit_word);
        cap             = (limit_word[62:0] > LONG_CAP) ? LONG_CAP : int'(limit_word[62:0]);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        goal            = bytes_queued + n_bytes;
        while (bytes_queued < goal)
            push_random_frame(cap);
        if (msg_open)
            push_frame(1'b1, OP_CONT, 0, LEN_ENC7, PAY_RANDOM);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Input driver: hold a stalled transaction, otherwise maybe advance
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                deframe_byte(in_byte);
            if (!in_valid || !in_stall) begin
                if (client_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    in_valid <= 1'b1;
                    in_byte  <= client_bytes.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor
    // ------------------------------------------------------------------
    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            fail_cnt++;
        end
    endtask

    task automatic check_result();
        t_ws_result want;
        if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual data %0h err %0d",
                     $time, out_data, error_code);
            fail_cnt++;
            return;
        end
        want = awaited_results.pop_front();
        checked_cnt++;
        compare_field("out_data", want.data, out_data);
        compare_field("data_valid", 8'(want.dv), 8'(data_valid));
        compare_field("frame_opcode", 8'(want.op), 8'(frame_opcode));
        compare_field("frame_fin", 8'(want.fin), 8'(frame_fin));
        compare_field("frame_end", 8'(want.fend), 8'(frame_end));
        compare_field("empty_frame", 8'(want.empty), 8'(empty_frame));
        compare_field("error_code", 8'(want.err), 8'(error_code));
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall)
                check_result();
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [3:0]  err_pick;
        logic [3:0]  op;
        int unsigned len;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset limit, no idling
        push_frame(1'b1, OP_TEXT, 3, LEN_ENC7, PAY_ZEROS);
        push_frame(1'b0, OP_BINARY, 2, LEN_ENC16, PAY_ONES);
        push_frame(1'b1, OP_PING, 1, LEN_ENC7, PAY_RANDOM);
        push_frame(1'b1, OP_PONG, 2, LEN_ENC7, PAY_RANDOM);
        push_frame(1'b1, OP_PONG, 0, LEN_ENC7, PAY_RANDOM);
        push_frame(1'b0, OP_CONT, 0, LEN_ENC64, PAY_RANDOM);
        push_frame(1'b1, OP_CONT, 1, LEN_ENC64, PAY_RANDOM);
        push_frame(1'b0, OP_TEXT, 1, LEN_ENC7, PAY_RANDOM);
        push_frame(1'b1, OP_CONT, 0, LEN_ENC16, PAY_RANDOM);
        push_frame(1'b1, OP_CLOSE, 0, LEN_ENC7, PAY_RANDOM);
        drain();

        // Random frames across limit settings and idle patterns
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 52, 0, 200);
        run_phase(64'd0, 0, 52, 70);
        run_phase(64'($urandom_range(140, 1)), 32, 32, 200);
        run_phase(64'(MAX_LEN_RESET), 0, 0, 170);
        run_phase(64'($urandom_range(100000, 200)), 32, 32, 170);

        // Small limit, a few frames, then one protocol error and trailing bytes
        write_frame_limit(64'($urandom_range(100, 0)));
        sender_idle_pct = 32;
        recv_stall_pct  = 32;
        for (int i = 0; i < 8; i++)
            push_random_frame(int'(frame_len_limit));
        err_pick = 4'($urandom_range(9, 1));
        op       = msg_open ? OP_CONT : OP_TEXT;
        case (err_pick)
            ERR_RSV: begin
                queue_byte({1'($urandom_range(1)), 3'($urandom_range(7, 1)),
                            4'($urandom_range(15))});
            end
            ERR_STRAY_CONT: begin
                if (msg_open)
                    push_frame(1'b1, OP_CONT, 0, LEN_ENC7, PAY_RANDOM);
                queue_byte({1'($urandom_range(1)), 3'b000, OP_CONT});
            end
            ERR_EXP_CONT: begin
                if (!msg_open)
                    push_frame(1'b0, OP_TEXT, 0, LEN_ENC7, PAY_RANDOM);
                queue_byte({1'($urandom_range(1)), 3'b000,
                            $urandom_range(1) ? OP_BINARY : OP_TEXT});
            end
            ERR_RSV_OP: begin
                len = $urandom_range(9);
                queue_byte({1'($urandom_range(1)), 3'b000,
                            (len < 5) ? 4'(3 + len) : 4'(6 + len)});
            end
            ERR_CTRL_FIN: begin
                queue_byte({1'b0, 3'b000, $urandom_range(1) ? OP_PING : OP_CLOSE});
            end
            ERR_UNMASKED: begin
                queue_byte({1'b1, 3'b000, op});
                queue_byte({1'b0, 7'($urandom_range(127))});
            end
            ERR_CTRL_EXT: begin
                queue_byte({1'b1, 3'b000, $urandom_range(1) ? OP_PONG : OP_PING});
                queue_byte({1'b1, $urandom_range(1) ? LEN64_CODE : LEN16_CODE});
            end
            ERR_LEN_TOP: begin
                queue_byte({1'b1, 3'b000, op});
                queue_byte({1'b1, LEN64_CODE});
                queue_byte({1'b1, 7'($urandom_range(127))});
                repeat (7) queue_byte(8'($urandom_range(255)));
            end
            default: begin
                // Over limit: one past the limit or more
                len = int'(frame_len_limit) + $urandom_range(20, 1);
                queue_byte({1'b1, 3'b000, op});
                if ($urandom_range(1)) begin
                    queue_byte({1'b1, 7'(len)});
                end else begin
                    queue_byte({1'b1, LEN16_CODE});
                    queue_byte(8'h00);
                    queue_byte(8'(len));
                end
            end
        endcase
        // Everything after the error must be dropped
        repeat (24) queue_byte(8'($urandom_range(255)));
        drain();

        $display("summary: %0d client bytes in %0d frames, %0d results checked",
                 bytes_queued, frames_sent, checked_cnt);
        $display("summary: %0d limit writes, closing protocol error code %0d",
                 limit_writes, err_pick);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
